// ===== sv/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared widths, operation codes and the packed types that travel between the
// ports, the control logic and the row of storage cells.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int OP_BITS    = 2;
  localparam int CAP_BITS   = 5;

  localparam logic [OP_BITS-1:0] OP_SET = 2'd0;
  localparam logic [OP_BITS-1:0] OP_GET = 2'd1;
  localparam logic [OP_BITS-1:0] OP_DEL = 2'd2;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [OP_BITS-1:0]    operation;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                  status;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
  } out_item_t;

  typedef struct packed {
    logic                  lookup;
    logic                  insert;
    logic                  evict;
    logic                  touch;
    logic                  remove;
    logic                  write_value;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } cell_cmd_t;

endpackage

// ===== sv/lkv_cell.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache storage cell
// Holds one entry (key, value, valid bit and recency rank), compares its key
// during lookup and applies the broadcast update. A free-slot chain passes
// from each cell to its neighbor so that the lowest free cell takes an insert.
// ----------------------------------------------------------------------------
module lkv_cell #(
  parameter int RANK_BITS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lkv_pkg::cell_cmd_t              cmd_i,
  input  logic [RANK_BITS-1:0]            ref_rank_i,
  input  logic [RANK_BITS-1:0]            oldest_rank_i,
  input  logic                            free_i,
  output logic                            free_o,
  output logic                            valid_o,
  output logic                            match_o,
  output logic [RANK_BITS-1:0]            hit_rank_o,
  output logic [lkv_pkg::VALUE_BITS-1:0]  hit_value_o,
  output logic [lkv_pkg::KEY_BITS-1:0]    victim_key_o
);

  logic [lkv_pkg::KEY_BITS-1:0]   key_r;
  logic [lkv_pkg::KEY_BITS-1:0]   key_nxt;
  logic [lkv_pkg::VALUE_BITS-1:0] value_r;
  logic [lkv_pkg::VALUE_BITS-1:0] value_nxt;
  logic                           valid_r;
  logic                           valid_nxt;
  logic [RANK_BITS-1:0]           rank_r;
  logic [RANK_BITS-1:0]           rank_nxt;
  logic                           match_r;
  logic                           match_nxt;
  logic                           oldest_r;
  logic                           oldest_nxt;
  logic                           is_free;
  logic                           take;

  assign is_free = !valid_r || (cmd_i.evict && oldest_r);
  assign take    = cmd_i.insert && is_free && !free_i;
  assign free_o  = free_i || is_free;

  always_comb begin
    key_nxt    = key_r;
    value_nxt  = value_r;
    valid_nxt  = valid_r;
    rank_nxt   = rank_r;
    match_nxt  = match_r;
    oldest_nxt = oldest_r;
    if (cmd_i.lookup) begin
      match_nxt  = valid_r && (key_r == cmd_i.key);
      oldest_nxt = valid_r && (rank_r == oldest_rank_i);
    end
    if (take) begin
      key_nxt   = cmd_i.key;
      value_nxt = cmd_i.value;
      valid_nxt = 1'b1;
      rank_nxt  = '0;
    end else if (cmd_i.evict && oldest_r) begin
      valid_nxt = 1'b0;
      rank_nxt  = '0;
    end else if (cmd_i.touch && match_r) begin
      rank_nxt = '0;
      if (cmd_i.write_value) begin
        value_nxt = cmd_i.value;
      end
    end else if (cmd_i.remove && match_r) begin
      valid_nxt = 1'b0;
      rank_nxt  = '0;
    end else if (valid_r) begin
      if (cmd_i.insert) begin
        rank_nxt = rank_r + RANK_BITS'(1);
      end else if (cmd_i.touch && (rank_r < ref_rank_i)) begin
        rank_nxt = rank_r + RANK_BITS'(1);
      end else if (cmd_i.remove && (rank_r > ref_rank_i)) begin
        rank_nxt = rank_r - RANK_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      rank_r   <= '0;
      match_r  <= 1'b0;
      oldest_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      rank_r   <= rank_nxt;
      match_r  <= match_nxt;
      oldest_r <= oldest_nxt;
    end
  end

  assign valid_o      = valid_r;
  assign match_o      = match_r;
  assign hit_rank_o   = match_r ? rank_r : '0;
  assign hit_value_o  = match_r ? value_r : '0;
  assign victim_key_o = oldest_r ? key_r : '0;

endmodule

// ===== sv/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fixed-capacity key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each transfer on the input channel carries one set, get or delete and gives
// exactly one result transfer. An item passes through a lookup state in
// which every cell of the entry row compares its key and flags the oldest
// entry, then an update state in which the row applies the new ranks, the
// write, the insert or the eviction. The next item is taken in the update
// state of the current one, so the block takes a new item while the last
// one is finishing; the result is registered when the update state completes,
// and the update state waits while an earlier result is still stalled.
// The capacity register may be written only while the block is idle.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  lkv_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output lkv_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [lkv_pkg::CAP_BITS-1:0]   cfg_wdata
);

  localparam int RW   = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (CW > lkv_pkg::CAP_BITS) ? CW : lkv_pkg::CAP_BITS;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0]                    state_r;
  logic [1:0]                    state_nxt;
  lkv_pkg::in_item_t             req_r;
  lkv_pkg::in_item_t             req_nxt;
  logic [CW-1:0]                 count_r;
  logic [CW-1:0]                 count_nxt;
  logic [lkv_pkg::CAP_BITS-1:0]  cap_r;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  lkv_pkg::out_item_t            out_data_r;
  lkv_pkg::out_item_t            out_data_nxt;

  logic                          in_take;
  logic                          can_out;
  logic                          do_update;
  logic [CMPW-1:0]               eff_cap;
  logic                          need_evict;
  logic                          hit;
  logic [RW-1:0]                 hit_rank;
  logic [lkv_pkg::VALUE_BITS-1:0] hit_value;
  logic [lkv_pkg::KEY_BITS-1:0]  victim_key;
  logic                          is_set;
  logic                          is_get;
  logic                          is_del;
  logic                          set_miss;
  lkv_pkg::cell_cmd_t            cmd;

  logic [ENTRIES:0]              free_c;
  logic [ENTRIES-1:0]            valid_v;
  logic [ENTRIES-1:0]            match_v;
  logic [RW-1:0]                 rank_v [ENTRIES];
  logic [lkv_pkg::VALUE_BITS-1:0] value_v [ENTRIES];
  logic [lkv_pkg::KEY_BITS-1:0]  ekey_v [ENTRIES];

  assign can_out   = !out_valid_r || !out_stall;
  assign do_update = (state_r == ST_UPDATE) && can_out;
  assign in_stall  = !rst_n || !((state_r == ST_IDLE) || do_update);
  assign in_take   = in_valid && !in_stall;

  assign is_set = (req_r.operation == lkv_pkg::OP_SET);
  assign is_get = (req_r.operation == lkv_pkg::OP_GET);
  assign is_del = (req_r.operation == lkv_pkg::OP_DEL);

  always_comb begin
    hit        = 1'b0;
    hit_rank   = '0;
    hit_value  = '0;
    victim_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit        = hit | match_v[i];
      hit_rank   = hit_rank | rank_v[i];
      hit_value  = hit_value | value_v[i];
      victim_key = victim_key | ekey_v[i];
    end
  end

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMPW'(1);
    end else if (CMPW'(cap_r) > CMPW'(ENTRIES)) begin
      eff_cap = CMPW'(ENTRIES);
    end else begin
      eff_cap = CMPW'(cap_r);
    end
  end

  assign need_evict = CMPW'(count_r) >= eff_cap;
  assign set_miss   = is_set && !hit;

  always_comb begin
    cmd             = '0;
    cmd.key         = req_r.key;
    cmd.value       = req_r.value;
    cmd.lookup      = (state_r == ST_LOOKUP);
    cmd.insert      = do_update && set_miss;
    cmd.evict       = do_update && set_miss && need_evict;
    cmd.touch       = do_update && hit && (is_set || is_get);
    cmd.write_value = is_set;
    cmd.remove      = do_update && hit && is_del;
  end

  assign free_c[0] = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkv_cell #(
      .RANK_BITS (RW)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .cmd_i         (cmd),
      .ref_rank_i    (hit_rank),
      .oldest_rank_i (RW'(count_r - CW'(1))),
      .free_i        (free_c[g]),
      .free_o        (free_c[g+1]),
      .valid_o       (valid_v[g]),
      .match_o       (match_v[g]),
      .hit_rank_o    (rank_v[g]),
      .hit_value_o   (value_v[g]),
      .victim_key_o  (ekey_v[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          req_nxt   = in_data;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (do_update) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = !(hit && (is_set || is_get || is_del));
          out_data_nxt.read_value  = (is_get && hit) ? hit_value : '0;
          out_data_nxt.evicted     = set_miss && need_evict;
          out_data_nxt.evicted_key = (set_miss && need_evict) ? victim_key : '0;
          if (is_del && hit) begin
            count_nxt = count_r - CW'(1);
          end else if (set_miss && !need_evict) begin
            count_nxt = count_r + CW'(1);
          end
          if (in_take) begin
            req_nxt   = in_data;
            state_nxt = ST_LOOKUP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= lkv_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("Entry count exceeds the number of cells.");

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_v) == count_r)
    else $error("Entry count disagrees with the valid cells.");

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |-> $onehot0(match_v))
    else $error("More than one cell matches the key.");

  a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_UPDATE))
    else $error("Result appeared without an update cycle.");
`endif

endmodule

// ===== bench/lru_key_value_cache_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives set, get and delete requests through the valid/stall input channel
// and checks every result against a fixed expectation or a cycle-free model
// of the store, across several capacities, with random idling on both channels.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;

  localparam int ENTRIES         = 16;
  localparam int KEY_POOL_SIZE   = 20;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int DRAIN_CYCLES    = 4;
  localparam int TAIL_CYCLES     = 20;
  localparam int CYCLE_LIMIT     = 200000;

  localparam logic [lkv_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;

  localparam lkv_pkg::out_item_t MISS     = lkv_pkg::out_item_t'({1'b1, 65'd0});
  localparam lkv_pkg::out_item_t HIT_ONES =
    lkv_pkg::out_item_t'({1'b0, 32'hFFFF_FFFF, 33'd0});
  localparam lkv_pkg::out_item_t HIT_ZERO = '0;

  typedef struct {
    bit                                 is_cfg;
    logic [lkv_pkg::OP_BITS-1:0]        op;
    logic [lkv_pkg::KEY_BITS-1:0]       key;
    logic [lkv_pkg::VALUE_BITS-1:0]     value;
    bit                                 typed;
    lkv_pkg::out_item_t                 want;
  } directed_row_t;

  // A configuration row carries the new capacity in its value field.
  directed_row_t directed_rows [22] = '{
    '{1'b0, lkv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, MISS},
    '{1'b0, lkv_pkg::OP_DEL, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, MISS},
    '{1'b0, OP_UNUSED,       32'h0000_0005, 32'h0000_0007, 1'b1, MISS},
    '{1'b0, lkv_pkg::OP_SET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, MISS},
    '{1'b0, lkv_pkg::OP_SET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, MISS},
    '{1'b0, lkv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, HIT_ONES},
    '{1'b0, lkv_pkg::OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, HIT_ZERO},
    '{1'b1, lkv_pkg::OP_SET, 32'h0000_0000, 32'h0000_0002, 1'b0, '0},
    '{1'b0, lkv_pkg::OP_SET, 32'h1234_5678, 32'h0000_0001, 1'b0, '0},
    '{1'b0, lkv_pkg::OP_SET, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b0, '0},
    '{1'b0, lkv_pkg::OP_GET, 32'h1234_5678, 32'h0000_0000, 1'b0, '0},
    '{1'b0, lkv_pkg::OP_SET, 32'hCAFE_F00D, 32'h0000_0003, 1'b0, '0},
    '{1'b0, lkv_pkg::OP_DEL, 32'h1234_5678, 32'h0000_0000, 1'b0, '0},
    '{1'b0, lkv_pkg::OP_DEL, 32'h1234_5678, 32'h0000_0000, 1'b0, '0},
    '{1'b0, OP_UNUSED,       32'hCAFE_F00D, 32'h0000_0000, 1'b1, MISS},
    '{1'b0, lkv_pkg::OP_GET, 32'hCAFE_F00D, 32'h0000_0000, 1'b0, '0},
    '{1'b1, lkv_pkg::OP_SET, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{1'b0, lkv_pkg::OP_SET, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 1'b0, '0},
    '{1'b0, lkv_pkg::OP_GET, 32'h5A5A_5A5A, 32'h0000_0000, 1'b0, '0},
    '{1'b1, lkv_pkg::OP_SET, 32'h0000_0000, 32'h0000_001F, 1'b0, '0},
    '{1'b0, lkv_pkg::OP_SET, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{1'b0, lkv_pkg::OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0}
  };

  logic [lkv_pkg::CAP_BITS-1:0] phase_caps [8] = '{
    lkv_pkg::CAP_RESET, 5'd5, 5'd0, 5'd1, 5'd17, 5'd3, 5'd31, 5'd8
  };

  logic                         clk;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  lkv_pkg::in_item_t            in_data   = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  lkv_pkg::out_item_t           out_data;
  logic                         cfg_we    = 1'b0;
  logic [lkv_pkg::CAP_BITS-1:0] cfg_wdata = '0;

  logic [lkv_pkg::KEY_BITS-1:0]   cache_key   [ENTRIES];
  logic [lkv_pkg::VALUE_BITS-1:0] cache_value [ENTRIES];
  bit                             cache_live  [ENTRIES];
  int                             cache_age   [ENTRIES];
  int                             cache_count;
  logic [lkv_pkg::CAP_BITS-1:0]   cache_cap;

  logic [lkv_pkg::KEY_BITS-1:0] key_pool [KEY_POOL_SIZE];
  lkv_pkg::out_item_t           pending_results [$];
  lkv_pkg::out_item_t           oldest_want;

  bit sender_idles = 1'b1;
  bit tail_quiet   = 1'b0;
  int errors       = 0;
  int cycles       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int hit_count    = 0;
  int evict_count  = 0;
  int caps_written = 0;

  lru_key_value_cache #(.ENTRIES(ENTRIES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void promote(int slot);
    int prior;
    prior = cache_age[slot];
    for (int i = 0; i < ENTRIES; i++) begin
      if (cache_live[i] && cache_age[i] < prior) cache_age[i]++;
    end
    cache_age[slot] = 0;
  endfunction

  function automatic void drop(int slot);
    int prior;
    prior = cache_age[slot];
    for (int i = 0; i < ENTRIES; i++) begin
      if (cache_live[i] && cache_age[i] > prior) cache_age[i]--;
    end
    cache_live[slot] = 1'b0;
    cache_age[slot]  = 0;
    if (cache_count > 0) cache_count--;
  endfunction

  function automatic lkv_pkg::out_item_t lru_predict(lkv_pkg::in_item_t item);
    lkv_pkg::out_item_t res;
    int                 hit;
    int                 oldest;
    int                 slot;
    int                 limit;
    res        = '0;
    res.status = 1'b1;
    hit        = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (cache_live[i] && cache_key[i] == item.key) hit = i;
    end
    limit = (cache_cap == 0) ? 1 : ((cache_cap > ENTRIES) ? ENTRIES : int'(cache_cap));
    case (item.operation)
      lkv_pkg::OP_SET: begin
        if (hit >= 0) begin
          res.status       = 1'b0;
          cache_value[hit] = item.value;
          promote(hit);
        end else begin
          if (cache_count >= limit) begin
            oldest = -1;
            for (int i = 0; i < ENTRIES; i++) begin
              if (cache_live[i] && (oldest < 0 || cache_age[i] > cache_age[oldest])) oldest = i;
            end
            if (oldest >= 0) begin
              res.evicted     = 1'b1;
              res.evicted_key = cache_key[oldest];
              drop(oldest);
            end
          end
          slot = -1;
          for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!cache_live[i]) slot = i;
          end
          if (slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (cache_live[i]) cache_age[i]++;
            end
            cache_key[slot]   = item.key;
            cache_value[slot] = item.value;
            cache_live[slot]  = 1'b1;
            cache_age[slot]   = 0;
            cache_count++;
          end
        end
      end
      lkv_pkg::OP_GET: begin
        if (hit >= 0) begin
          res.status     = 1'b0;
          res.read_value = cache_value[hit];
          promote(hit);
        end
      end
      lkv_pkg::OP_DEL: begin
        if (hit >= 0) begin
          res.status = 1'b0;
          drop(hit);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic lkv_pkg::in_item_t random_item();
    lkv_pkg::in_item_t item;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      item.operation = lkv_pkg::OP_SET;
    else if (pick < 80) item.operation = lkv_pkg::OP_GET;
    else if (pick < 95) item.operation = lkv_pkg::OP_DEL;
    else                item.operation = OP_UNUSED;
    if ($urandom_range(0, 9) == 0) item.key = $urandom;
    else                           item.key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    case ($urandom_range(0, 15))
      0:       item.value = '0;
      1:       item.value = '1;
      default: item.value = $urandom;
    endcase
    return item;
  endfunction

  // Returns at the edge where the transfer happens, with in_valid still high.
  task automatic send_item(input lkv_pkg::in_item_t item, input bit typed,
                           input lkv_pkg::out_item_t want);
    lkv_pkg::out_item_t guess;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    guess = lru_predict(item);
    pending_results.push_back(typed ? want : guess);
    items_sent++;
  endtask

  task automatic pause_sender();
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [lkv_pkg::CAP_BITS-1:0] cap);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cache_cap = cap;
    cfg_we    <= 1'b0;
    caps_written++;
  endtask

  task automatic compare_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, expected none, actual %h", $time, out_data);
      end else begin
        oldest_want = pending_results.pop_front();
        compare_field("status", 32'(oldest_want.status), 32'(out_data.status));
        compare_field("read_value", oldest_want.read_value, out_data.read_value);
        compare_field("evicted", 32'(oldest_want.evicted), 32'(out_data.evicted));
        compare_field("evicted_key", oldest_want.evicted_key, out_data.evicted_key);
        if (!out_data.status) hit_count++;
        if (out_data.evicted) evict_count++;
      end
    end
  end

  initial begin
    forever begin
      if (tail_quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        if ($urandom_range(0, 1) == 1) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 10)) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles,
               pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    lkv_pkg::in_item_t row_item;
    for (int i = 0; i < ENTRIES; i++) begin
      cache_key[i]   = '0;
      cache_value[i] = '0;
      cache_live[i]  = 1'b0;
      cache_age[i]   = 0;
    end
    cache_count = 0;
    cache_cap   = lkv_pkg::CAP_RESET;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        drain_results();
        write_capacity(directed_rows[r].value[lkv_pkg::CAP_BITS-1:0]);
      end else begin
        row_item.operation = directed_rows[r].op;
        row_item.key       = directed_rows[r].key;
        row_item.value     = directed_rows[r].value;
        send_item(row_item, directed_rows[r].typed, directed_rows[r].want);
        pause_sender();
      end
    end

    // Each phase starts from an idle block, so the sender waits out every result.
    foreach (phase_caps[p]) begin
      drain_results();
      write_capacity(phase_caps[p]);
      tail_quiet   = (p == $size(phase_caps) - 1);
      sender_idles = !tail_quiet && ($urandom_range(0, 3) != 0);
      repeat (ITEMS_PER_PHASE) begin
        send_item(random_item(), 1'b0, '0);
        pause_sender();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests under %0d capacity writes, including out-of-range values.",
             items_sent, caps_written);
    $display("Checked %0d results: %0d hits, %0d misses, %0d evictions, %0d errors.",
             results_seen, hit_count, results_seen - hit_count, evict_count, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
